// File: rtl/core/slt_pkg.sv
// slt_pkg: token kinds, scanner states, result types, keyword table and
// character class functions for the source lexer tokenizer.
// No dependencies.
`default_nettype none

package slt_pkg;

  localparam logic [5:0] KIND_ATTR   = 6'd0;
  localparam logic [5:0] KIND_ID     = 6'd18;
  localparam logic [5:0] KIND_NUM    = 6'd19;
  localparam logic [5:0] KIND_REAL   = 6'd20;
  localparam logic [5:0] KIND_LIT    = 6'd21;
  localparam logic [5:0] KIND_PLUS   = 6'd22;
  localparam logic [5:0] KIND_MINUS  = 6'd23;
  localparam logic [5:0] KIND_MUL    = 6'd24;
  localparam logic [5:0] KIND_DIV    = 6'd25;
  localparam logic [5:0] KIND_LPAREN = 6'd26;
  localparam logic [5:0] KIND_RPAREN = 6'd27;
  localparam logic [5:0] KIND_LBLOCK = 6'd28;
  localparam logic [5:0] KIND_RBLOCK = 6'd29;
  localparam logic [5:0] KIND_SEMI   = 6'd30;
  localparam logic [5:0] KIND_COMMA  = 6'd31;
  localparam logic [5:0] KIND_LT     = 6'd32;
  localparam logic [5:0] KIND_GT     = 6'd33;
  localparam logic [5:0] KIND_LE     = 6'd34;
  localparam logic [5:0] KIND_GE     = 6'd35;
  localparam logic [5:0] KIND_EXCL   = 6'd36;
  localparam logic [5:0] KIND_NE     = 6'd37;
  localparam logic [5:0] KIND_EQ     = 6'd38;
  localparam logic [5:0] KIND_ASSIGN = 6'd39;
  localparam logic [5:0] KIND_ERR    = 6'd40;
  localparam logic [5:0] KIND_EOF    = 6'd41;
  localparam logic [5:0] KIND_AND    = 6'd42;
  localparam logic [5:0] KIND_OR     = 6'd43;
  localparam logic [5:0] KIND_MAX    = KIND_OR;

  typedef enum logic [4:0] {
    ST_START, ST_AFTER_DIV, ST_LINE_CMT, ST_BLOCK_CMT, ST_BSTAR, ST_NUM, ST_REAL,
    ST_EXPONENT, ST_WORD, ST_DOTTED, ST_CMP, ST_EXCL, ST_EQ, ST_LIT, ST_ESCAPE,
    ST_OCT1, ST_OCT2, ST_AND, ST_OR
  } scan_e;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] attr_char;
    logic       last;
  } tok_t;

  // up to two result items per input item, in order
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } scan_res_t;

  localparam int KW_COUNT    = 17;
  localparam int KW_TEXT_LEN = 8;

  // right-justified text; keyword k has kind k + 1
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    64'("boolean"), 64'("break"), 64'("class"), 64'("continue"), 64'("do"),
    64'("double"), 64'("else"), 64'("false"), 64'("for"), 64'("if"), 64'("int"),
    64'("return"), 64'("String"), 64'("static"), 64'("true"), 64'("void"),
    64'("while")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd5, 4'd5, 4'd8, 4'd2, 4'd6, 4'd4, 4'd5,
    4'd3, 4'd2, 4'd3, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_" || c == "$";
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_MUL;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBLOCK;
      "}":     k = KIND_RBLOCK;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      default: k = KIND_ATTR;
    endcase
    return k;
  endfunction

  function automatic logic ends_token(input logic [7:0] c);
    return is_space(c) || single_code(c) != KIND_ATTR || c == "/" || c == "<" ||
           c == ">" || c == "=" || c == "!" || c == "\"" || c == "|" || c == "&";
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/slt_char_if.sv
// slt_char_if: input channel, one source character per item.
// No dependencies.
`default_nettype none

interface slt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, char_in, end_of_input, input ready);
  modport sink (input valid, char_in, end_of_input, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slt_tok_if.sv
// slt_tok_if: result channel, one token kind or attribute byte per item.
// No dependencies.
`default_nettype none

interface slt_tok_if;
  logic       valid;
  logic       ready;
  logic [5:0] kind;
  logic [7:0] attr_char;
  logic       last;

  modport source (output valid, kind, attr_char, last, input ready);
  modport sink (input valid, kind, attr_char, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slt_kw_match.sv
// slt_kw_match: parallel compare of the stored word prefix against all
// keywords. Depends on slt_pkg.
`default_nettype none

module slt_kw_match #(
  parameter int KeywordMaxLen = 8,
  localparam int WlenW = $clog2(KeywordMaxLen + 2)
) (
  input  logic [7:0]       prefix_i [KeywordMaxLen],
  input  logic [WlenW-1:0] wlen_i,
  output logic [5:0]       code_o
);

  always_comb begin
    logic        hit;
    logic [63:0] kw;
    code_o = slt_pkg::KIND_ID;
    for (int k = slt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      kw  = slt_pkg::KW_STR[k] <<
            (8 * (slt_pkg::KW_TEXT_LEN - int'(slt_pkg::KW_LEN[k])));
      hit = (wlen_i == WlenW'(slt_pkg::KW_LEN[k]));
      for (int i = 0; i < slt_pkg::KW_TEXT_LEN; i++) begin
        if (i < int'(slt_pkg::KW_LEN[k]) &&
            prefix_i[i] != kw[8*(slt_pkg::KW_TEXT_LEN-1-i) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        code_o = 6'(k + 1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slt_scan.sv
// slt_scan: lexer automaton state and its next-state / result logic.
// Depends on slt_pkg and slt_kw_match.
`default_nettype none

module slt_scan #(
  parameter int KeywordMaxLen = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic [7:0]             char_i,
  input  logic                   eoi_i,
  output slt_pkg::scan_res_t     res_o
);

  localparam int WlenW = $clog2(KeywordMaxLen + 2);
  localparam int IdxW  = $clog2(KeywordMaxLen);

  slt_pkg::scan_e    st_q, st_d;
  logic              seen_q, seen_d;
  logic [WlenW-1:0]  wlen_q, wlen_d;
  logic [8:0]        oct_q, oct_d;
  logic              lt_q, lt_d;
  logic [7:0]        pfx_q [KeywordMaxLen];

  logic              pw_en;
  logic [IdxW-1:0]   pw_idx;
  logic [5:0]        kw_code;
  logic [7:0]        c;

  // start-state decode of the current character
  slt_pkg::scan_e    ss;
  logic              s_v, s_word, s_op;
  logic [5:0]        s_k;
  logic [7:0]        s_a;

  logic              pre_v, body_v, clr, do_start;
  logic [5:0]        pre_k, body_k;
  logic [7:0]        body_a;
  logic [8:0]        oct_sum;
  logic              oct_ok;

  assign c       = eoi_i ? 8'(" ") : char_i;
  assign oct_sum = oct_q + {6'd0, c[2:0]};
  assign oct_ok  = slt_pkg::is_oct(c) && oct_sum != 9'd0 && !oct_sum[8];

  slt_kw_match #(.KeywordMaxLen(KeywordMaxLen)) u_kw_match (
    .prefix_i (pfx_q),
    .wlen_i   (wlen_q),
    .code_o   (kw_code)
  );

  always_comb begin
    ss     = slt_pkg::ST_START;
    s_v    = 1'b0;
    s_k    = slt_pkg::KIND_ATTR;
    s_a    = 8'd0;
    s_word = 1'b0;
    s_op   = 1'b0;
    if (slt_pkg::is_space(c)) begin
      ss = slt_pkg::ST_START;
    end else if (slt_pkg::is_alpha(c) || c == "_" || c == "$") begin
      ss = slt_pkg::ST_WORD; s_v = 1'b1; s_a = c; s_word = 1'b1;
    end else if (slt_pkg::is_digit(c)) begin
      ss = slt_pkg::ST_NUM; s_v = 1'b1; s_a = c;
    end else if (c == "/") begin
      ss = slt_pkg::ST_AFTER_DIV;
    end else if (slt_pkg::single_code(c) != slt_pkg::KIND_ATTR) begin
      s_v = 1'b1; s_k = slt_pkg::single_code(c);
    end else if (c == "<" || c == ">") begin
      ss = slt_pkg::ST_CMP; s_op = 1'b1;
    end else if (c == "!") begin
      ss = slt_pkg::ST_EXCL; s_op = 1'b1;
    end else if (c == "=") begin
      ss = slt_pkg::ST_EQ; s_op = 1'b1;
    end else if (c == "\"") begin
      ss = slt_pkg::ST_LIT;
    end else if (c == "&") begin
      ss = slt_pkg::ST_AND; s_op = 1'b1;
    end else if (c == "|") begin
      ss = slt_pkg::ST_OR; s_op = 1'b1;
    end else begin
      s_v = 1'b1; s_k = slt_pkg::KIND_ERR;
    end
  end

  // result items
  always_comb begin
    pre_v    = 1'b0;
    pre_k    = slt_pkg::KIND_ATTR;
    body_v   = 1'b0;
    body_k   = slt_pkg::KIND_ATTR;
    body_a   = 8'd0;
    do_start = 1'b0;
    res_o    = '0;

    case (st_q)
      slt_pkg::ST_AFTER_DIV: begin
        if (c != "/" && c != "*") begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_DIV; do_start = 1'b1;
        end
      end
      slt_pkg::ST_LINE_CMT, slt_pkg::ST_BLOCK_CMT, slt_pkg::ST_BSTAR: begin
      end
      slt_pkg::ST_NUM: begin
        if (slt_pkg::is_digit(c) || c == "E" || c == "e" || c == ".") begin
          body_v = 1'b1; body_a = c;
        end else if (slt_pkg::ends_token(c)) begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_NUM; do_start = 1'b1;
        end else begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_EXPONENT: begin
        if (((c == "+" || c == "-") && !seen_q) || slt_pkg::is_digit(c)) begin
          body_v = 1'b1; body_a = c;
        end else if (slt_pkg::ends_token(c)) begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_REAL; do_start = 1'b1;
        end else begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_REAL: begin
        if (slt_pkg::is_digit(c) || ((c == "E" || c == "e") && seen_q)) begin
          body_v = 1'b1; body_a = c;
        end else if (slt_pkg::ends_token(c) && seen_q) begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_REAL; do_start = 1'b1;
        end else begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_WORD: begin
        if (slt_pkg::is_wordch(c) || c == ".") begin
          body_v = 1'b1; body_a = c;
        end else if (slt_pkg::ends_token(c)) begin
          pre_v = 1'b1; pre_k = kw_code; do_start = 1'b1;
        end else begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_DOTTED: begin
        if (slt_pkg::is_wordch(c)) begin
          body_v = 1'b1; body_a = c;
        end else if (seen_q && slt_pkg::ends_token(c)) begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_ID; do_start = 1'b1;
        end else begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_CMP: begin
        if (c == "=") begin
          body_v = 1'b1;
          body_k = lt_q ? slt_pkg::KIND_LE : slt_pkg::KIND_GE;
        end else begin
          pre_v = 1'b1; do_start = 1'b1;
          pre_k = lt_q ? slt_pkg::KIND_LT : slt_pkg::KIND_GT;
        end
      end
      slt_pkg::ST_EXCL: begin
        if (c == "=") begin
          body_v = 1'b1; body_k = slt_pkg::KIND_NE;
        end else begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_EXCL; do_start = 1'b1;
        end
      end
      slt_pkg::ST_EQ: begin
        if (c == "=") begin
          body_v = 1'b1; body_k = slt_pkg::KIND_EQ;
        end else begin
          pre_v = 1'b1; pre_k = slt_pkg::KIND_ASSIGN; do_start = 1'b1;
        end
      end
      slt_pkg::ST_AND: begin
        body_v = 1'b1;
        body_k = (c == "&") ? slt_pkg::KIND_AND : slt_pkg::KIND_ERR;
      end
      slt_pkg::ST_OR: begin
        body_v = 1'b1;
        body_k = (c == "|") ? slt_pkg::KIND_OR : slt_pkg::KIND_ERR;
      end
      slt_pkg::ST_LIT: begin
        if (c == "\"") begin
          body_v = 1'b1; body_k = slt_pkg::KIND_LIT;
        end else if (c == "\\") begin
          body_v = 1'b0;
        end else if (c == "\n") begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end else begin
          body_v = 1'b1; body_a = c;
        end
      end
      slt_pkg::ST_ESCAPE: begin
        if (c == "\"" || c == "\\") begin
          body_v = 1'b1; body_a = c;
        end else if (c == "n") begin
          body_v = 1'b1; body_a = 8'("\n");
        end else if (c == "t") begin
          body_v = 1'b1; body_a = 8'("\t");
        end else if (!slt_pkg::is_oct(c)) begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_OCT1: begin
        if (!slt_pkg::is_oct(c)) begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      slt_pkg::ST_OCT2: begin
        if (oct_ok) begin
          body_v = 1'b1; body_a = oct_sum[7:0];
        end else begin
          body_v = 1'b1; body_k = slt_pkg::KIND_ERR;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      body_v = s_v; body_k = s_k; body_a = s_a;
    end

    // order: token code ending the previous token, then this character's item
    if (pre_v) begin
      res_o.tok0 = '{kind: pre_k, attr_char: 8'd0, last: !body_v};
      res_o.tok1 = '{kind: body_k, attr_char: body_a, last: 1'b1};
      res_o.cnt  = body_v ? 2'd2 : 2'd1;
    end else begin
      res_o.tok0 = '{kind: body_k, attr_char: body_a, last: 1'b1};
      res_o.cnt  = body_v ? 2'd1 : 2'd0;
    end

    if (eoi_i) begin
      if (res_o.cnt == 2'd0) begin
        res_o.tok0 = '{kind: slt_pkg::KIND_EOF, attr_char: 8'd0, last: 1'b1};
        res_o.cnt  = 2'd1;
      end else begin
        res_o.tok0.last = 1'b0;
        res_o.tok1 = '{kind: slt_pkg::KIND_EOF, attr_char: 8'd0, last: 1'b1};
        res_o.cnt  = 2'd2;
      end
    end
  end

  // next state
  always_comb begin
    st_d   = st_q;
    seen_d = seen_q;
    wlen_d = wlen_q;
    oct_d  = oct_q;
    lt_d   = lt_q;
    pw_en  = 1'b0;
    pw_idx = wlen_q[IdxW-1:0];
    clr    = 1'b0;

    case (st_q)
      slt_pkg::ST_AFTER_DIV: begin
        if (c == "/") st_d = slt_pkg::ST_LINE_CMT;
        else if (c == "*") st_d = slt_pkg::ST_BLOCK_CMT;
      end
      slt_pkg::ST_LINE_CMT: begin
        if (c == "\n") clr = 1'b1;
      end
      slt_pkg::ST_BLOCK_CMT: begin
        if (c == "*") st_d = slt_pkg::ST_BSTAR;
      end
      slt_pkg::ST_BSTAR: begin
        if (c == "/") clr = 1'b1;
        else if (c != "*") st_d = slt_pkg::ST_BLOCK_CMT;
      end
      slt_pkg::ST_NUM: begin
        if (c == "E" || c == "e") begin
          st_d = slt_pkg::ST_EXPONENT; seen_d = 1'b0;
        end else if (c == ".") begin
          st_d = slt_pkg::ST_REAL; seen_d = 1'b0;
        end else if (!slt_pkg::is_digit(c) && !slt_pkg::ends_token(c)) begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_EXPONENT: begin
        if (((c == "+" || c == "-") && !seen_q) || slt_pkg::is_digit(c)) begin
          seen_d = 1'b1;
        end else if (!slt_pkg::ends_token(c)) begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_REAL: begin
        if (slt_pkg::is_digit(c)) begin
          seen_d = 1'b1;
        end else if ((c == "E" || c == "e") && seen_q) begin
          st_d = slt_pkg::ST_EXPONENT; seen_d = 1'b0;
        end else if (!(slt_pkg::ends_token(c) && seen_q)) begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_WORD: begin
        if (slt_pkg::is_wordch(c)) begin
          pw_en = (wlen_q < WlenW'(KeywordMaxLen));
          if (wlen_q <= WlenW'(KeywordMaxLen)) wlen_d = wlen_q + WlenW'(1);
        end else if (c == ".") begin
          st_d = slt_pkg::ST_DOTTED; seen_d = 1'b0;
        end else if (!slt_pkg::ends_token(c)) begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_DOTTED: begin
        if (slt_pkg::is_wordch(c)) begin
          seen_d = 1'b1;
        end else if (!(seen_q && slt_pkg::ends_token(c))) begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_CMP, slt_pkg::ST_EXCL, slt_pkg::ST_EQ: begin
        if (c == "=") clr = 1'b1;
      end
      slt_pkg::ST_AND, slt_pkg::ST_OR: begin
        clr = 1'b1;
      end
      slt_pkg::ST_LIT: begin
        if (c == "\"") clr = 1'b1;
        else if (c == "\\") st_d = slt_pkg::ST_ESCAPE;
        else if (c == "\n") clr = 1'b1;
      end
      slt_pkg::ST_ESCAPE: begin
        if (c == "\"" || c == "\\" || c == "n" || c == "t") begin
          st_d = slt_pkg::ST_LIT;
        end else if (slt_pkg::is_oct(c)) begin
          st_d = slt_pkg::ST_OCT1; oct_d = {c[2:0], 6'd0};
        end else begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_OCT1: begin
        if (slt_pkg::is_oct(c)) begin
          st_d = slt_pkg::ST_OCT2; oct_d = oct_q + {3'd0, c[2:0], 3'd0};
        end else begin
          clr = 1'b1;
        end
      end
      slt_pkg::ST_OCT2: begin
        if (oct_ok) begin
          st_d = slt_pkg::ST_LIT; oct_d = 9'd0;
        end else begin
          clr = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (clr) begin
      st_d = slt_pkg::ST_START; seen_d = 1'b0; wlen_d = '0; oct_d = 9'd0;
    end
    if (do_start) begin
      st_d   = ss;
      seen_d = 1'b0;
      wlen_d = s_word ? WlenW'(1) : '0;
      oct_d  = 9'd0;
      if (s_op) lt_d = (c == "<");
      if (s_word) begin
        pw_en = 1'b1; pw_idx = '0;
      end
    end

    if (eoi_i) begin
      st_d = slt_pkg::ST_START; seen_d = 1'b0; wlen_d = '0; oct_d = 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= slt_pkg::ST_START;
      seen_q <= 1'b0;
      wlen_q <= '0;
      oct_q  <= 9'd0;
    end else if (adv_i) begin
      st_q   <= st_d;
      seen_q <= seen_d;
      wlen_q <= wlen_d;
      oct_q  <= oct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lt_q <= lt_d;
      if (pw_en) pfx_q[pw_idx] <= c;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slt_res_fifo.sv
// slt_res_fifo: four-entry result queue, up to two items in and one out per
// cycle. Depends on slt_pkg.
`default_nettype none

module slt_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slt_pkg::scan_res_t push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output slt_pkg::tok_t      head_o,
  output logic               room_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  slt_pkg::tok_t     mem_q [Depth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;
  logic [1:0]        n_push;
  logic              do_pop;

  assign n_push  = push_i ? push_data_i.cnt : 2'd0;
  assign do_pop  = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];
  assign room_o  = (cnt_q <= (PtrW+1)'(Depth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PtrW'(n_push);
      rp_q  <= rp_q + PtrW'(do_pop);
      cnt_q <= cnt_q + (PtrW+1)'(n_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wp_q] <= push_data_i.tok0;
    if (n_push == 2'd2) mem_q[wp_q + PtrW'(1)] <= push_data_i.tok1;
  end

endmodule

`default_nettype wire

// File: rtl/core/source_lexer_tokenizer.sv
// source_lexer_tokenizer: top level; input register, lexer automaton and
// result queue. Depends on slt_pkg, slt_char_if, slt_tok_if, slt_scan, slt_res_fifo.
//
//   port   dir  modport  item
//   in_i   in   sink     char_in[7:0], end_of_input
//   res_o  out  source   kind[5:0], attr_char[7:0], last
//
// One character per cycle enters the input register while the result queue has
// room; the automaton and the keyword compare decide it from that register and
// write 0 to 2 items into a four-entry result queue, which drains one item per
// cycle while the consumer is ready, so a character giving two items leaves it
// one item at a time. Queue holding more than two items stalls the input.
// Reset is asynchronous, active low, and takes the automaton to its start state.
`default_nettype none

module source_lexer_tokenizer #(
  parameter int KEYWORD_MAX_LEN = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slt_char_if.sink   in_i,
  slt_tok_if.source  res_o
);

  logic               v_q;
  logic [7:0]         char_q;
  logic               eoi_q;
  logic               room;
  logic               adv;
  slt_pkg::scan_res_t scan_res;
  slt_pkg::tok_t      head;

  assign adv        = v_q && room;
  assign in_i.ready = !v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_i.ready) begin
      v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_in;
      eoi_q  <= in_i.end_of_input;
    end
  end

  slt_scan #(.KeywordMaxLen(KEYWORD_MAX_LEN)) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .char_i (char_q),
    .eoi_i  (eoi_q),
    .res_o  (scan_res)
  );

  slt_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv),
    .push_data_i (scan_res),
    .pop_i       (res_o.ready),
    .valid_o     (res_o.valid),
    .head_o      (head),
    .room_o      (room)
  );

  assign res_o.kind      = head.kind;
  assign res_o.attr_char = head.attr_char;
  assign res_o.last      = head.last;

endmodule

`default_nettype wire

// File: rtl/core/slt_checker.sv
// slt_checker: port-level assertions for source_lexer_tokenizer, bound to it.
// Depends on slt_pkg.
`default_nettype none

module slt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [5:0] kind_i,
  input logic [7:0] attr_char_i,
  input logic       last_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(kind_i) &&
    $stable(attr_char_i) && $stable(last_i))
    else $error("result item changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> kind_i <= slt_pkg::KIND_MAX)
    else $error("reserved kind");

  a_attr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i != slt_pkg::KIND_ATTR |-> attr_char_i == 8'd0)
    else $error("attribute byte on a token item");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i == slt_pkg::KIND_EOF |-> last_i)
    else $error("eof item not marked last");

endmodule

bind source_lexer_tokenizer slt_checker u_slt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .kind_i      (res_o.kind),
  .attr_char_i (res_o.attr_char),
  .last_i      (res_o.last)
);

`default_nettype wire
